[hdl/matrix_multiply_macros.svh]
// ---------------------------------------------------------------------------
// matrix_multiply_macros.svh
// Assertion shorthands shared by the matrix multiply checkers.
// ---------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH

// Same-cycle implication, sampled on clock, idle during reset
`define MM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, idle during reset
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/mm_pkg.sv]
// ---------------------------------------------------------------------------
// mm_pkg
// Sizes, codes and shared types of the matrix multiply block.
// ---------------------------------------------------------------------------
package mm_pkg;

   // Largest supported matrix side
   localparam int MAX_DIM   = 8;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;

   // Fixed field widths
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int ELEM_W    = 16;
   localparam int OUT_W     = 35;
   localparam int IDX_W     = 3;

   // Derived widths
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int ACC_NAT_W = PROD_W + $clog2(MAX_DIM) + 1;
   localparam int ACC_W     = (ACC_NAT_W > OUT_W) ? ACC_NAT_W : OUT_W + 1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS  = 2'd0,
      CSR_INNER = 2'd1,
      CSR_COLS  = 2'd2
   } csr_index_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic run_start;
      logic issue;
      logic capture;
      logic next_elem;
      logic clear_counts;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic load_done;
      logic issue_last;
      logic pipe_empty;
      logic elem_last;
   } dp_stat_type;

   // Force a configured side into 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   // Clip the accumulator into the signed output range
   function automatic logic [OUT_W-1:0] saturate(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-OUT_W:0] hi;
      logic [OUT_W-1:0]     r;
      hi = acc[ACC_W-1:OUT_W-1];
      if ((&hi) || (~|hi)) begin
         r = acc[OUT_W-1:0];
      end else if (acc[ACC_W-1]) begin
         r = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(OUT_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

[hdl/mm_ctrl.sv]
// ---------------------------------------------------------------------------
// mm_ctrl
// Sequencer: load phase, per-element multiply-accumulate, result handoff.
// ---------------------------------------------------------------------------
module mm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mm_pkg::dp_cmd_type  cmd,
   input  mm_pkg::dp_stat_type stat
);

   mm_pkg::state_type state_ff;
   mm_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         mm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (stat.load_done) begin
                  cmd.run_start = 1'b1;
                  state_in      = mm_pkg::ST_MAC;
               end
            end
         end
         mm_pkg::ST_MAC: begin
            cmd.issue = 1'b1;
            if (stat.issue_last) begin
               state_in = mm_pkg::ST_DRAIN;
            end
         end
         mm_pkg::ST_DRAIN: begin
            if (stat.pipe_empty) begin
               cmd.capture = 1'b1;
               state_in    = mm_pkg::ST_EMIT;
            end
         end
         mm_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (stat.elem_last) begin
                  cmd.clear_counts = 1'b1;
                  state_in         = mm_pkg::ST_IDLE;
               end else begin
                  cmd.next_elem = 1'b1;
                  state_in      = mm_pkg::ST_MAC;
               end
            end
         end
         default: begin
            state_in = mm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/mm_dpath.sv]
// ---------------------------------------------------------------------------
// mm_dpath
// Config registers, matrix stores, address walk, multiply-accumulate
// pipeline and output register.
// ---------------------------------------------------------------------------
module mm_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [mm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mm_pkg::CFG_W-1:0]              csr_data,
   input  logic                                  req_kind,
   input  logic signed [mm_pkg::ELEM_W-1:0]      req_element,
   output logic signed [mm_pkg::OUT_W-1:0]       rsp_product_value,
   output logic [mm_pkg::IDX_W-1:0]              rsp_out_row,
   output logic [mm_pkg::IDX_W-1:0]              rsp_out_column,
   output logic                                  rsp_last_element,
   input  mm_pkg::dp_cmd_type                    cmd,
   output mm_pkg::dp_stat_type                   stat
);

   localparam int CNT_W  = mm_pkg::CNT_W;
   localparam int DIM_W  = mm_pkg::DIM_W;
   localparam int ADDR_W = mm_pkg::ADDR_W;

   // Configuration registers
   logic [mm_pkg::CFG_W-1:0] rows_cfg_ff, inner_cfg_ff, cols_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= mm_pkg::CFG_W'(8);
         inner_cfg_ff <= mm_pkg::CFG_W'(8);
         cols_cfg_ff  <= mm_pkg::CFG_W'(8);
      end else if (csr_write) begin
         case (mm_pkg::csr_index_type'(csr_index))
            mm_pkg::CSR_ROWS:  rows_cfg_ff  <= csr_data;
            mm_pkg::CSR_INNER: inner_cfg_ff <= csr_data;
            mm_pkg::CSR_COLS:  cols_cfg_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Effective sizes
   logic [DIM_W-1:0] rows, inner, cols;
   logic [CNT_W-1:0] left_total, right_total;

   assign rows        = mm_pkg::clamp_dim(rows_cfg_ff);
   assign inner       = mm_pkg::clamp_dim(inner_cfg_ff);
   assign cols        = mm_pkg::clamp_dim(cols_cfg_ff);
   assign left_total  = CNT_W'(rows) * CNT_W'(inner);
   assign right_total = CNT_W'(inner) * CNT_W'(cols);

   // Load counts
   logic [CNT_W-1:0] left_loaded_ff, right_loaded_ff;
   logic [CNT_W-1:0] left_loaded_in, right_loaded_in;
   logic             left_we, right_we;

   assign left_we  = cmd.load && !req_kind && (left_loaded_ff < left_total);
   assign right_we = cmd.load && req_kind && (right_loaded_ff < right_total);

   always_comb begin
      left_loaded_in  = left_loaded_ff + CNT_W'(left_we);
      right_loaded_in = right_loaded_ff + CNT_W'(right_we);
      if (cmd.clear_counts) begin
         left_loaded_in  = '0;
         right_loaded_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_loaded_ff  <= '0;
         right_loaded_ff <= '0;
      end else begin
         left_loaded_ff  <= left_loaded_in;
         right_loaded_ff <= right_loaded_in;
      end
   end

   // Both matrices full once this beat lands
   assign stat.load_done = (left_loaded_in >= left_total) && (right_loaded_in >= right_total);

   // Element walk: i rows, j columns, p along the inner side
   logic [DIM_W-1:0] i_ff, j_ff, p_ff;
   logic [CNT_W-1:0] row_base_ff, a_addr_ff, b_addr_ff;
   logic             row_end;

   assign row_end         = (j_ff + DIM_W'(1)) == cols;
   assign stat.issue_last = (p_ff + DIM_W'(1)) == inner;

   always_ff @(posedge clock) begin
      if (cmd.run_start) begin
         i_ff        <= '0;
         j_ff        <= '0;
         p_ff        <= '0;
         row_base_ff <= '0;
         a_addr_ff   <= '0;
         b_addr_ff   <= '0;
      end else if (cmd.next_elem) begin
         p_ff <= '0;
         if (row_end) begin
            i_ff        <= i_ff + DIM_W'(1);
            j_ff        <= '0;
            row_base_ff <= row_base_ff + CNT_W'(inner);
            a_addr_ff   <= row_base_ff + CNT_W'(inner);
            b_addr_ff   <= '0;
         end else begin
            j_ff      <= j_ff + DIM_W'(1);
            a_addr_ff <= row_base_ff;
            b_addr_ff <= CNT_W'(j_ff) + CNT_W'(1);
         end
      end else if (cmd.issue) begin
         p_ff      <= p_ff + DIM_W'(1);
         a_addr_ff <= a_addr_ff + CNT_W'(1);
         b_addr_ff <= b_addr_ff + CNT_W'(cols);
      end
   end

   // Matrix stores with registered read
   logic [mm_pkg::ELEM_W-1:0]        left_mem  [mm_pkg::DEPTH];
   logic [mm_pkg::ELEM_W-1:0]        right_mem [mm_pkg::DEPTH];
   logic signed [mm_pkg::ELEM_W-1:0] a_rd_ff, b_rd_ff;

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[left_loaded_ff[ADDR_W-1:0]] <= req_element;
      end
      a_rd_ff <= left_mem[a_addr_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[right_loaded_ff[ADDR_W-1:0]] <= req_element;
      end
      b_rd_ff <= right_mem[b_addr_ff[ADDR_W-1:0]];
   end

   // Multiply-accumulate pipeline: read, multiply, accumulate
   logic                              rd_vld_ff, prod_vld_ff;
   logic signed [mm_pkg::PROD_W-1:0]  prod_ff;
   logic signed [mm_pkg::ACC_W-1:0]   acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * b_rd_ff;
      if (cmd.run_start || cmd.next_elem) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + mm_pkg::ACC_W'(prod_ff);
      end
   end

   assign stat.pipe_empty = !rd_vld_ff && !prod_vld_ff;

   // Output register, held while the result beat is stalled
   logic [mm_pkg::OUT_W-1:0] value_ff;
   logic [mm_pkg::IDX_W-1:0] row_ff, col_ff;
   logic                     last_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff <= mm_pkg::saturate(acc_ff);
         row_ff   <= mm_pkg::IDX_W'(i_ff);
         col_ff   <= mm_pkg::IDX_W'(j_ff);
         last_ff  <= ((i_ff + DIM_W'(1)) == rows) && row_end;
      end
   end

   assign stat.elem_last    = last_ff;
   assign rsp_product_value = value_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_out_column    = col_ff;
   assign rsp_last_element  = last_ff;

endmodule

[hdl/matrix_multiply.sv]
// Loading: one element beat per cycle, no result until both matrices are full.
// Compute: the completing beat starts the run; each product element takes
// inner_count store reads through the 3-stage multiply-accumulate pipeline,
// a drain and one output beat, all on the single shared multiplier.
// Input is stalled from the completing beat until the last result is taken.
// Synchronous reset clears counts and state and sets all three sizes to 8.
// ---------------------------------------------------------------------------
// matrix_multiply
// Fixed-point general matrix multiply: loads A and B element by element,
// then streams the product in row-major order.
// ---------------------------------------------------------------------------
module matrix_multiply (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [mm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mm_pkg::CFG_W-1:0]              csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic signed [mm_pkg::ELEM_W-1:0]      req_element,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mm_pkg::OUT_W-1:0]       rsp_product_value,
   output logic [mm_pkg::IDX_W-1:0]              rsp_out_row,
   output logic [mm_pkg::IDX_W-1:0]              rsp_out_column,
   output logic                                  rsp_last_element
);

   mm_pkg::dp_cmd_type  cmd;
   mm_pkg::dp_stat_type stat;

   // Sequencer
   mm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Stores and arithmetic
   mm_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_kind          (req_kind),
      .req_element       (req_element),
      .rsp_product_value (rsp_product_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_column    (rsp_out_column),
      .rsp_last_element  (rsp_last_element),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

[hdl/mm_checker.sv]
// ---------------------------------------------------------------------------
// mm_checker
// Port-level checks of the matrix multiply block, bound to the top level.
// ---------------------------------------------------------------------------
`include "matrix_multiply_macros.svh"

module mm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [mm_pkg::OUT_W-1:0]        rsp_product_value,
   input logic [mm_pkg::IDX_W-1:0]        rsp_out_row,
   input logic [mm_pkg::IDX_W-1:0]        rsp_out_column,
   input logic                            rsp_last_element
);

   logic [mm_pkg::OUT_W+2*mm_pkg::IDX_W:0] rsp_beat;
   logic                                   rsp_hold;
   logic                                   rsp_take_last;
   logic                                   rsp_take_mid;
   logic                                   load_open;

   // Collect the result beat and the handshake terms
   assign rsp_beat      = {rsp_product_value, rsp_out_row, rsp_out_column, rsp_last_element};
   assign rsp_hold      = rsp_valid && rsp_stall;
   assign rsp_take_last = rsp_valid && !rsp_stall && rsp_last_element;
   assign rsp_take_mid  = rsp_valid && !rsp_stall && !rsp_last_element;
   assign load_open     = !rsp_valid && !req_stall;

   // Hold a stalled result beat
   `MM_ASSERT_NEXT(a_rsp_hold, rsp_hold, rsp_valid && $stable(rsp_beat), "stalled beat changed")

   // No input beats while results go out
   `MM_ASSERT_SAME(a_no_load_in_run, rsp_valid, req_stall, "input open during result stream")

   // Drop back to loading after the last element
   `MM_ASSERT_NEXT(a_idle_after_last, rsp_take_last, load_open, "block not idle after last")

   // Stay busy between elements of one run
   `MM_ASSERT_NEXT(a_busy_mid_run, rsp_take_mid, req_stall && !rsp_valid, "run ended early")

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);
